>>> rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg: shared types and constants of the keyframe track sampler
// Key record layout, field codes, fixed-point constants and the constant
// tables of the sine polynomial.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kts_pkg;

  // Track depth default
  localparam int MAX_KEYS = 64;

  // Datapath widths
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 33;

  // Input item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Value kinds
  localparam logic VK_VECTOR = 1'b0;
  localparam logic VK_QUAT   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_VALUE_KIND   = 2'd0;
  localparam logic [1:0] REG_TRACK_TARGET = 2'd1;
  localparam logic [1:0] REG_KEY_COUNT    = 2'd2;

  // Target and result slot codes
  localparam logic [1:0] SLOT_POS   = 2'd0;
  localparam logic [1:0] SLOT_SCALE = 2'd1;
  localparam logic [1:0] SLOT_ROT   = 2'd2;
  localparam logic [1:0] SLOT_NONE  = 2'd3;

  // Q2.30 constants; COS_LERP_MIN is Q16.16
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [49:0] COS_LERP_MIN = 50'd65536;

  // Index of the last polynomial step in one sine evaluation
  localparam logic [2:0] POLY_LAST = 3'd4;

  // One stored keyframe
  typedef struct packed {
    logic signed [31:0] tval;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } key_t;

  // Divisor k*(k+1) of polynomial step i, k running 10, 8, 6, 4, 2
  function automatic logic [6:0] poly_div(input logic [2:0] i);
    logic [6:0] d;
    case (i)
      3'd0:    d = 7'd110;
      3'd1:    d = 7'd72;
      3'd2:    d = 7'd42;
      3'd3:    d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) of polynomial step i
  function automatic logic [29:0] poly_recip(input logic [2:0] i);
    logic [29:0] m;
    case (i)
      3'd0:    m = 30'd39045157;
      3'd1:    m = 30'd59652323;
      3'd2:    m = 30'd102261126;
      3'd3:    m = 30'd214748364;
      default: m = 30'd715827882;
    endcase
    return m;
  endfunction

  // Clip a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    logic signed [31:0] r;
    if (v > 70'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -70'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/kts_key_store.sv
// ----------------------------------------------------------------------------
// kts_key_store: keyframe memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kts_key_store #(
  parameter int DEPTH = kts_pkg::MAX_KEYS,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire kts_pkg::key_t wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output kts_pkg::key_t      rdata_o
);

  kts_pkg::key_t mem_q [DEPTH];
  kts_pkg::key_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/kts_mul.sv
// ----------------------------------------------------------------------------
// kts_mul: shared signed multiplier
// Product of the two operands, registered every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kts_mul (
  input  wire logic                                clk_i,
  input  wire logic signed [kts_pkg::MUL_W-1:0]    a_i,
  input  wire logic signed [kts_pkg::MUL_W-1:0]    b_i,
  output logic signed [kts_pkg::PROD_W-1:0]        p_o
);

  logic signed [kts_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> rtl/kts_div.sv
// ----------------------------------------------------------------------------
// kts_div: shared unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when the
// quotient is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kts_div (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic [kts_pkg::DIVIDEND_W-1:0]       dividend_i,
  input  wire logic [kts_pkg::DIVISOR_W-1:0]        divisor_i,
  output logic                                      done_o,
  output logic [kts_pkg::DIVIDEND_W-1:0]            quotient_o
);

  localparam int NW = kts_pkg::DIVIDEND_W;
  localparam int DW = kts_pkg::DIVISOR_W;
  localparam int CW = $clog2(NW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, dvs_q;
  logic [NW-1:0] quo_q;

  logic [DW:0]   rem_sh, rem_sub;
  logic          ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, quo_q[NW-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quo_q <= {quo_q[NW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/keyframe_track_sampler_top.sv
// ----------------------------------------------------------------------------
// keyframe_track_sampler_top: animation track sampler
// Stores keyframes and samples the track by linear mix or slerp.
//
//   channel   direction  handshake                payload
//   in        input      in_valid_i / in_ready_o  kind, key_index, time, comps
//   out       output     out_valid_o/out_ready_i  slot, out_x..out_w
//   cfg       input      cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// A load is written straight to the key memory. An empty or mismatched
// sample skips to the output; a clamped one returns key 0 (low end) or the
// last key (high end). A vector sample scans the keys linearly and gets its
// mix factor from the divider. A quaternion sample also scans, then runs an angle
// bisection (one sine evaluation per step on the one multiplier) and four
// weighted divides in the bit-serial divider, unless it falls back to the linear mix.
// Reset clears control and configuration; the key memory is not cleared.
// in_ready_o is high only while idle; a result waits in the output register
// and the next item is taken while it stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyframe_track_sampler_top #(
  parameter int MAX_KEYS = kts_pkg::MAX_KEYS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item input
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic [5:0]         key_index_i,
  input  wire logic signed [31:0] time_value_i,
  input  wire logic signed [31:0] comp_x_i,
  input  wire logic signed [31:0] comp_y_i,
  input  wire logic signed [31:0] comp_z_i,
  input  wire logic signed [31:0] comp_w_i,
  // result output
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              slot_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic signed [31:0]      out_w_o,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [6:0]         cfg_wdata_i
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int MW = kts_pkg::MUL_W;

  typedef enum logic [28:0] {
    S_IDLE  = 29'd1 << 0,
    S_RD0   = 29'd1 << 1,
    S_RD1   = 29'd1 << 2,
    S_LAST  = 29'd1 << 3,
    S_SCAN  = 29'd1 << 4,
    S_PV    = 29'd1 << 5,
    S_FDIV  = 29'd1 << 6,
    S_LMUL  = 29'd1 << 7,
    S_LADD  = 29'd1 << 8,
    S_DMUL  = 29'd1 << 9,
    S_DACC  = 29'd1 << 10,
    S_DSIGN = 29'd1 << 11,
    S_BS    = 29'd1 << 12,
    S_SX2   = 29'd1 << 13,
    S_ST    = 29'd1 << 14,
    S_SPM   = 29'd1 << 15,
    S_SRM   = 29'd1 << 16,
    S_SCOR  = 29'd1 << 17,
    S_SFIN  = 29'd1 << 18,
    S_SOUT  = 29'd1 << 19,
    S_WAM   = 29'd1 << 20,
    S_WAX   = 29'd1 << 21,
    S_WBM   = 29'd1 << 22,
    S_WBX   = 29'd1 << 23,
    S_WM1   = 29'd1 << 24,
    S_WM2   = 29'd1 << 25,
    S_WSUM  = 29'd1 << 26,
    S_WDIV  = 29'd1 << 27,
    S_FIN   = 29'd1 << 28
  } state_e;

  // where a sine evaluation returns to
  typedef enum logic [1:0] {
    RET_BS,
    RET_TH,
    RET_WA,
    RET_WB
  } sin_ret_e;

  state_e   state_q;
  sin_ret_e ret_q;

  // configuration
  logic       vk_q;
  logic [1:0] tgt_q;
  logic [6:0] kc_q;

  // sample context
  logic [1:0]         slot_q;
  logic signed [31:0] tm_q, t1_q;
  logic [AW-1:0]      last_q, idx_q;
  logic signed [MW-1:0] a_q [4];
  logic signed [MW-1:0] b_q [4];
  logic [15:0]        f_q;
  logic signed [49:0] c_q;
  logic [30:0]        lo_q, hi_q, mid_q, th_q, x_q, t_q, cmp_q, s_q, wa_q, wb_q;
  logic [32:0]        x2_q, v_q;
  logic [2:0]         k_q;
  logic signed [63:0] acc_q;
  logic               neg_q;
  logic [1:0]         j_q;
  logic signed [31:0] r_q [4];

  // output register
  logic               out_valid_q;
  logic [1:0]         oslot_q;
  logic signed [31:0] ox_q, oy_q, oz_q, ow_q;

  // shared units
  kts_pkg::key_t      wr_key, rd_key;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [kts_pkg::PROD_W-1:0] p_q;
  logic               div_start, div_done;
  logic [63:0]        div_num, div_quo;
  logic [32:0]        div_den;

  // combinational helpers
  logic               accept;
  logic [1:0]         slot_c;
  logic [31:0]        n_c;
  logic               hit;
  logic signed [32:0] dtm, dkt;
  logic               fcond;
  logic               last_j;
  logic [30:0]        sin_w, mid_c;
  logic [31:0]        span;
  logic signed [49:0] c_abs;
  logic [29:0]        q0;
  logic [39:0]        rem_c;
  logic [30:0]        qq;
  logic signed [63:0] num_c, mag_c;
  logic signed [69:0] lin_c;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // slot and key count of a new sample
  always_comb begin
    if (vk_q == kts_pkg::VK_VECTOR) begin
      slot_c = (tgt_q == kts_pkg::SLOT_POS || tgt_q == kts_pkg::SLOT_SCALE) ?
               tgt_q : kts_pkg::SLOT_NONE;
    end else begin
      slot_c = (tgt_q == kts_pkg::SLOT_ROT) ? kts_pkg::SLOT_ROT : kts_pkg::SLOT_NONE;
    end
    n_c = (32'(kc_q) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : 32'(kc_q);
    if (n_c == 32'd0) begin
      slot_c = kts_pkg::SLOT_NONE;
    end
  end

  // key memory
  assign wr_en  = accept && (kind_i == kts_pkg::KIND_LOAD) &&
                  (32'(key_index_i) < 32'(MAX_KEYS));
  assign wr_key = '{tval: time_value_i, x: comp_x_i, y: comp_y_i,
                    z: comp_z_i, w: comp_w_i};

  assign hit = ($signed(rd_key.tval) > tm_q) || (idx_q == last_q);

  // read address: key 0 is fetched while idle, the last key in S_RD1
  always_comb begin
    case (state_q)
      S_RD1:   rd_addr = last_q;
      S_LAST:  rd_addr = AW'(1);
      S_SCAN:  rd_addr = hit ? idx_q - 1'b1 : idx_q + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  kts_key_store #(.DEPTH(MAX_KEYS)) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(key_index_i)),
    .wdata_i (wr_key),
    .raddr_i (rd_addr),
    .rdata_o (rd_key)
  );

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_LMUL: begin
        mul_a = b_q[j_q] - a_q[j_q];
        mul_b = {18'd0, f_q};
      end
      S_DMUL: begin
        mul_a = a_q[j_q];
        mul_b = b_q[j_q];
      end
      S_SX2: begin
        mul_a = {3'd0, x_q};
        mul_b = {3'd0, x_q};
      end
      S_SPM: begin
        mul_a = {1'b0, x2_q};
        mul_b = {3'd0, t_q};
      end
      S_SRM: begin
        mul_a = {1'b0, p_q[62:30]};
        mul_b = {4'd0, kts_pkg::poly_recip(k_q)};
      end
      S_SFIN: begin
        mul_a = {3'd0, x_q};
        mul_b = {3'd0, t_q};
      end
      S_WAM: begin
        mul_a = {3'd0, th_q};
        mul_b = {17'd0, 17'h10000 - {1'b0, f_q}};
      end
      S_WBM: begin
        mul_a = {3'd0, th_q};
        mul_b = {18'd0, f_q};
      end
      S_WM1: begin
        mul_a = {3'd0, wa_q};
        mul_b = a_q[j_q];
      end
      S_WM2: begin
        mul_a = {3'd0, wb_q};
        mul_b = b_q[j_q];
      end
      default: begin
      end
    endcase
  end

  kts_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_q)
  );

  // arithmetic around the shared units
  always_comb begin
    dtm    = 33'(tm_q) - 33'(rd_key.tval);
    dkt    = 33'(t1_q) - 33'(rd_key.tval);
    fcond  = (t1_q > rd_key.tval) && (tm_q >= rd_key.tval) && (tm_q < t1_q);
    last_j = (vk_q == kts_pkg::VK_VECTOR) ? (j_q == 2'd2) : (j_q == 2'd3);
    lin_c  = 70'(a_q[j_q]) + 70'((p_q + 68'sd32768) >>> 16);
    c_abs  = c_q[49] ? -c_q : c_q;
    span   = 32'(hi_q) - 32'(lo_q) + 32'd1;
    mid_c  = lo_q + span[31:1];
    sin_w  = p_q[60:30];
    q0     = p_q[61:32];
    rem_c  = 40'(v_q) - 40'(q0) * 40'(kts_pkg::poly_div(k_q));
    qq     = 31'(q0) + ((rem_c >= 40'(kts_pkg::poly_div(k_q))) ? 31'd1 : 31'd0);
    num_c  = acc_q + 64'(p_q);
    mag_c  = num_c[63] ? -num_c : num_c;
  end

  // divider operands
  assign div_start = ((state_q == S_PV) && fcond) || (state_q == S_WSUM);
  always_comb begin
    if (state_q == S_PV) begin
      div_num = {16'd0, dtm[31:0], 16'd0};
      div_den = dkt;
    end else begin
      div_num = mag_c + 64'(s_q >> 1);
      div_den = {2'd0, s_q};
    end
  end

  kts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= RET_BS;
      vk_q        <= 1'b0;
      tgt_q       <= '0;
      kc_q        <= '0;
      slot_q      <= kts_pkg::SLOT_NONE;
      tm_q        <= '0;
      t1_q        <= '0;
      last_q      <= '0;
      idx_q       <= '0;
      f_q         <= '0;
      c_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      th_q        <= '0;
      x_q         <= '0;
      t_q         <= '0;
      cmp_q       <= '0;
      s_q         <= '0;
      wa_q        <= '0;
      wb_q        <= '0;
      x2_q        <= '0;
      v_q         <= '0;
      k_q         <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      j_q         <= '0;
      for (int i = 0; i < 4; i++) begin
        a_q[i] <= '0;
        b_q[i] <= '0;
        r_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      oslot_q     <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      oz_q        <= '0;
      ow_q        <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kts_pkg::REG_VALUE_KIND:   vk_q  <= cfg_wdata_i[0];
          kts_pkg::REG_TRACK_TARGET: tgt_q <= cfg_wdata_i[1:0];
          kts_pkg::REG_KEY_COUNT:    kc_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      // result transfer; S_FIN refills the register itself
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept && kind_i == kts_pkg::KIND_SAMPLE) begin
            slot_q <= slot_c;
            tm_q   <= time_value_i;
            last_q <= AW'(n_c - 32'd1);
            f_q    <= '0;
            c_q    <= '0;
            for (int i = 0; i < 4; i++) begin
              r_q[i] <= '0;
            end
            state_q <= (slot_c == kts_pkg::SLOT_NONE) ? S_FIN : S_RD0;
          end
        end
        S_RD0: state_q <= S_RD1;
        // key 0 on the read port: clamp low
        S_RD1: begin
          if (tm_q <= rd_key.tval) begin
            r_q[0]  <= rd_key.x;
            r_q[1]  <= rd_key.y;
            r_q[2]  <= rd_key.z;
            r_q[3]  <= (vk_q == kts_pkg::VK_QUAT) ? rd_key.w : 32'sd0;
            state_q <= S_FIN;
          end else begin
            state_q <= S_LAST;
          end
        end
        // last key on the read port: clamp high
        S_LAST: begin
          if (tm_q >= rd_key.tval) begin
            r_q[0]  <= rd_key.x;
            r_q[1]  <= rd_key.y;
            r_q[2]  <= rd_key.z;
            r_q[3]  <= (vk_q == kts_pkg::VK_QUAT) ? rd_key.w : 32'sd0;
            state_q <= S_FIN;
          end else begin
            idx_q   <= AW'(1);
            state_q <= S_SCAN;
          end
        end
        // linear scan for the next key
        S_SCAN: begin
          if (hit) begin
            t1_q    <= rd_key.tval;
            b_q[0]  <= MW'(rd_key.x);
            b_q[1]  <= MW'(rd_key.y);
            b_q[2]  <= MW'(rd_key.z);
            b_q[3]  <= MW'(rd_key.w);
            state_q <= S_PV;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        // previous key on the read port
        S_PV: begin
          a_q[0] <= MW'(rd_key.x);
          a_q[1] <= MW'(rd_key.y);
          a_q[2] <= MW'(rd_key.z);
          a_q[3] <= MW'(rd_key.w);
          j_q    <= '0;
          if (fcond) begin
            state_q <= S_FDIV;
          end else begin
            state_q <= (vk_q == kts_pkg::VK_QUAT) ? S_DMUL : S_LMUL;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            f_q     <= div_quo[15:0];
            state_q <= (vk_q == kts_pkg::VK_QUAT) ? S_DMUL : S_LMUL;
          end
        end
        // linear mix, one component per pass
        S_LMUL: state_q <= S_LADD;
        S_LADD: begin
          r_q[j_q] <= kts_pkg::sat32(lin_c);
          j_q      <= j_q + 1'b1;
          state_q  <= last_j ? S_FIN : S_LMUL;
        end
        // quaternion dot product
        S_DMUL: state_q <= S_DACC;
        S_DACC: begin
          c_q     <= c_q + 50'(p_q >>> 16);
          j_q     <= j_q + 1'b1;
          state_q <= (j_q == 2'd3) ? S_DSIGN : S_DMUL;
        end
        // shortest path and linear fallback
        S_DSIGN: begin
          if (c_q[49]) begin
            for (int i = 0; i < 4; i++) begin
              b_q[i] <= -b_q[i];
            end
          end
          j_q <= '0;
          if (c_abs >= kts_pkg::COS_LERP_MIN) begin
            state_q <= S_LMUL;
          end else begin
            cmp_q   <= {1'b0, c_abs[15:0], 14'd0};
            lo_q    <= '0;
            hi_q    <= kts_pkg::HALF_PI_Q30;
            state_q <= S_BS;
          end
        end
        // angle bisection
        S_BS: begin
          if (lo_q < hi_q) begin
            mid_q <= mid_c;
            x_q   <= kts_pkg::HALF_PI_Q30 - mid_c;
            ret_q <= RET_BS;
          end else begin
            th_q  <= lo_q;
            x_q   <= lo_q;
            ret_q <= RET_TH;
          end
          state_q <= S_SX2;
        end
        // sine evaluation
        S_SX2: state_q <= S_ST;
        S_ST: begin
          x2_q    <= p_q[62:30];
          t_q     <= kts_pkg::ONE_Q30;
          k_q     <= '0;
          state_q <= S_SPM;
        end
        S_SPM: state_q <= S_SRM;
        S_SRM: begin
          v_q     <= p_q[62:30];
          state_q <= S_SCOR;
        end
        S_SCOR: begin
          t_q <= kts_pkg::ONE_Q30 - qq;
          if (k_q == kts_pkg::POLY_LAST) begin
            state_q <= S_SFIN;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_SPM;
          end
        end
        S_SFIN: state_q <= S_SOUT;
        S_SOUT: begin
          case (ret_q)
            RET_BS: begin
              if (sin_w >= cmp_q) begin
                lo_q <= mid_q;
              end else begin
                hi_q <= mid_q - 1'b1;
              end
              state_q <= S_BS;
            end
            RET_TH: begin
              s_q <= sin_w;
              j_q <= '0;
              state_q <= (sin_w == 31'd0) ? S_LMUL : S_WAM;
            end
            RET_WA: begin
              wa_q    <= sin_w;
              state_q <= S_WBM;
            end
            RET_WB: begin
              wb_q    <= sin_w;
              j_q     <= '0;
              state_q <= S_WM1;
            end
            default: state_q <= S_BS;
          endcase
        end
        // weight angles
        S_WAM: state_q <= S_WAX;
        S_WAX: begin
          x_q     <= p_q[46:16];
          ret_q   <= RET_WA;
          state_q <= S_SX2;
        end
        S_WBM: state_q <= S_WBX;
        S_WBX: begin
          x_q     <= p_q[46:16];
          ret_q   <= RET_WB;
          state_q <= S_SX2;
        end
        // weighted sum over sin(th), one component per pass
        S_WM1: state_q <= S_WM2;
        S_WM2: begin
          acc_q   <= 64'(p_q);
          state_q <= S_WSUM;
        end
        S_WSUM: begin
          neg_q   <= num_c[63];
          state_q <= S_WDIV;
        end
        S_WDIV: begin
          if (div_done) begin
            if (neg_q) begin
              r_q[j_q] <= (div_quo > 64'h80000000) ? 32'sh80000000 :
                          -$signed(div_quo[31:0]);
            end else begin
              r_q[j_q] <= (div_quo > 64'h7fffffff) ? 32'sh7fffffff :
                          $signed(div_quo[31:0]);
            end
            j_q     <= j_q + 1'b1;
            state_q <= (j_q == 2'd3) ? S_FIN : S_WM1;
          end
        end
        // hand the result to the output register
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            oslot_q     <= slot_q;
            ox_q        <= r_q[0];
            oy_q        <= r_q[1];
            oz_q        <= r_q[2];
            ow_q        <= r_q[3];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = oslot_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign out_w_o     = ow_q;

endmodule

`default_nettype wire

>>> rtl/kts_checker.sv
// ----------------------------------------------------------------------------
// kts_checker: port-level assertions of the track sampler
// Watches the top-level ports; attached by the bind below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kts_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               kind_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [1:0]         slot_o,
  input wire logic signed [31:0] out_x_o,
  input wire logic signed [31:0] out_y_o,
  input wire logic signed [31:0] out_z_o,
  input wire logic signed [31:0] out_w_o
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a sample transfer makes the block busy
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == kts_pkg::KIND_SAMPLE |=> !in_ready_o)
    else $error("input still ready after a sample transfer");

  // a new result only comes out of a busy period
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a sample in work");

  // nothing written means all components zero
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_o == kts_pkg::SLOT_NONE |->
      out_x_o == 32'sd0 && out_y_o == 32'sd0 && out_z_o == 32'sd0 && out_w_o == 32'sd0)
    else $error("empty result with nonzero components");

  // vector results carry no w
  a_vec_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (slot_o == kts_pkg::SLOT_POS || slot_o == kts_pkg::SLOT_SCALE) |->
      out_w_o == 32'sd0)
    else $error("vector result with nonzero w");

endmodule

bind keyframe_track_sampler_top kts_checker u_kts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .slot_o      (slot_o),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o),
  .out_w_o     (out_w_o)
);

`default_nettype wire
